FILE: hw/rtl/qes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qes_pkg
// Shared types and constants of the quadratic equation solver pipeline.
// ----------------------------------------------------------------------------
package qes_pkg;

    localparam int COEF_WIDTH_DEF = 40;
    localparam int FRAC_BITS_DEF  = 32;
    localparam int THR_W          = 32;
    localparam int ROOT_W         = 64;
    localparam int CFG_IDX_W      = 1;

    localparam logic [THR_W-1:0] ZERO_THR_RST  = 32'd429;
    localparam logic [THR_W-1:0] RATIO_THR_RST = 32'd429497;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_ONE  = 2'd1,
        OUT_TWO  = 2'd2,
        OUT_INF  = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_THR  = 1'b0,
        CFG_RATIO_THR = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_outcome outcome;
        logic     linear;
        logic     neg_a;
        logic     neg_b;
        logic     neg_c;
    } t_flags;

    typedef struct packed {
        logic neg;
        logic num_neg;
        logic num_zero;
        logic den_zero;
    } t_lane;

endpackage
`default_nettype wire

FILE: hw/rtl/quadratic_equation_solver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_equation_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, fully pipelined.
// The square root and the two-lane divider resolve one result bit per stage.
// Throughput: one transaction per cycle; the whole pipe holds on output stall.
// Reset: clears all valid bits and loads the threshold registers.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_top import qes_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_square,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_linear,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_const,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_outcome,
    output logic                              o_was_linear,
    output logic signed [ROOT_W-1:0]          o_root_first,
    output logic signed [ROOT_W-1:0]          o_root_second,
    output logic                              o_saturated,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [THR_W-1:0]             i_cfg_data
);

    localparam int CW  = COEF_WIDTH;
    localparam int NW  = CW + 1;
    localparam int DNW = CW + 1;
    localparam int QW  = NW + FRAC_BITS;
    localparam int DW  = 2 * CW + 1;

    logic [THR_W-1:0] r_zero_thr, r_ratio_thr;
    logic             en;

    logic          fr_valid;
    t_flags        fr_flags;
    logic [CW-1:0] fr_am, fr_bm, fr_cm;
    logic [DW-1:0] fr_dis;

    logic          sq_valid;
    logic [NW-1:0] sq_root;
    t_flags        sq_flags;
    logic [CW-1:0] sq_am, sq_bm, sq_cm;

    logic                r_op_v;
    t_flags              r_op_flags;
    t_lane [1:0]         r_op_lane;
    logic [1:0][QW-1:0]  r_op_num;
    logic [1:0][DNW-1:0] r_op_den;

    t_lane [1:0]         n_lane;
    logic [1:0][NW-1:0]  n_nmag;
    logic [1:0][DNW-1:0] n_dmag;
    logic [1:0]          n_nneg, n_dneg;
    logic [NW-1:0]       bm_e;
    logic [DNW-1:0]      am2;

    logic                dv_valid;
    t_flags              dv_flags;
    t_lane [1:0]         dv_lane;
    logic [1:0][QW-1:0]  dv_quot;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_thr  <= ZERO_THR_RST;
            r_ratio_thr <= RATIO_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZERO_THR:  r_zero_thr  <= i_cfg_data;
                CFG_RATIO_THR: r_ratio_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qes_front #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_a         (i_coef_square),
        .i_b         (i_coef_linear),
        .i_c         (i_coef_const),
        .i_zero_thr  (r_zero_thr),
        .i_ratio_thr (r_ratio_thr),
        .o_valid     (fr_valid),
        .o_flags     (fr_flags),
        .o_am        (fr_am),
        .o_bm        (fr_bm),
        .o_cm        (fr_cm),
        .o_dis       (fr_dis)
    );

    qes_sqrt #(.COEF_WIDTH(COEF_WIDTH)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_dis   (fr_dis),
        .i_flags (fr_flags),
        .i_am    (fr_am),
        .i_bm    (fr_bm),
        .i_cm    (fr_cm),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_flags (sq_flags),
        .o_am    (sq_am),
        .o_bm    (sq_bm),
        .o_cm    (sq_cm)
    );

    // numerator and divisor of each root
    always_comb begin
        bm_e   = NW'(sq_bm);
        am2    = DNW'(sq_am) << 1;
        n_nmag = '0;
        n_dmag = '0;
        n_nneg = '0;
        n_dneg = '0;
        case (sq_flags.outcome)
            OUT_ONE: begin
                if (sq_flags.linear) begin
                    n_nneg[0] = !sq_flags.neg_c;
                    n_nmag[0] = NW'(sq_cm);
                    n_dneg[0] = sq_flags.neg_b;
                    n_dmag[0] = DNW'(sq_bm);
                end else begin
                    n_nneg[0] = !sq_flags.neg_b;
                    n_nmag[0] = bm_e;
                    n_dneg[0] = sq_flags.neg_a;
                    n_dmag[0] = am2;
                end
            end
            OUT_TWO: begin
                if (sq_flags.neg_b) begin
                    n_nneg[0] = 1'b0;
                    n_nmag[0] = bm_e + sq_root;
                    if (bm_e >= sq_root) begin
                        n_nneg[1] = 1'b0;
                        n_nmag[1] = bm_e - sq_root;
                    end else begin
                        n_nneg[1] = 1'b1;
                        n_nmag[1] = sq_root - bm_e;
                    end
                end else begin
                    if (sq_root >= bm_e) begin
                        n_nneg[0] = 1'b0;
                        n_nmag[0] = sq_root - bm_e;
                    end else begin
                        n_nneg[0] = 1'b1;
                        n_nmag[0] = bm_e - sq_root;
                    end
                    n_nneg[1] = 1'b1;
                    n_nmag[1] = bm_e + sq_root;
                end
                n_dneg = {2{sq_flags.neg_a}};
                n_dmag = {2{am2}};
            end
            default: ;
        endcase
        for (int l = 0; l < 2; l++) begin
            n_lane[l].neg      = n_nneg[l] ^ n_dneg[l];
            n_lane[l].num_neg  = n_nneg[l];
            n_lane[l].num_zero = n_nmag[l] == '0;
            n_lane[l].den_zero = n_dmag[l] == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_v <= 1'b0;
        end else if (en) begin
            r_op_v <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op_flags  <= sq_flags;
            r_op_lane   <= n_lane;
            r_op_num[0] <= QW'(n_nmag[0]) << FRAC_BITS;
            r_op_num[1] <= QW'(n_nmag[1]) << FRAC_BITS;
            r_op_den    <= n_dmag;
        end
    end

    qes_div #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_op_v),
        .i_flags (r_op_flags),
        .i_lane  (r_op_lane),
        .i_num   (r_op_num),
        .i_den   (r_op_den),
        .o_valid (dv_valid),
        .o_flags (dv_flags),
        .o_lane  (dv_lane),
        .o_quot  (dv_quot)
    );

    qes_finish #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (dv_valid),
        .i_flags       (dv_flags),
        .i_lane        (dv_lane),
        .i_quot        (dv_quot),
        .i_zero_thr    (r_zero_thr),
        .o_valid       (o_out_valid),
        .o_outcome     (o_outcome),
        .o_was_linear  (o_was_linear),
        .o_root_first  (o_root_first),
        .o_root_second (o_root_second),
        .o_saturated   (o_saturated)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/qes_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qes_front
// Magnitudes, split products, linear decision, discriminant and outcome.
// ----------------------------------------------------------------------------
module qes_front import qes_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COEF_WIDTH-1:0] i_a,
    input  wire logic signed [COEF_WIDTH-1:0] i_b,
    input  wire logic signed [COEF_WIDTH-1:0] i_c,
    input  wire logic [THR_W-1:0]             i_zero_thr,
    input  wire logic [THR_W-1:0]             i_ratio_thr,
    output logic                              o_valid,
    output t_flags                            o_flags,
    output logic [COEF_WIDTH-1:0]             o_am,
    output logic [COEF_WIDTH-1:0]             o_bm,
    output logic [COEF_WIDTH-1:0]             o_cm,
    output logic [2*COEF_WIDTH:0]             o_dis
);

    localparam int CW   = COEF_WIDTH;
    localparam int HW   = (CW + 1) / 2;
    localparam int HH   = CW - HW;
    localparam int PW   = 2 * CW;
    localparam int RW   = CW + THR_W;
    localparam int DW   = 2 * CW + 1;
    localparam int CMPW = (DW > THR_W + FRAC_BITS) ? DW : THR_W + FRAC_BITS;
    localparam int MCW  = (CW > THR_W) ? CW : THR_W;

    // stage 1
    logic          r1_v, r1_an, r1_bn, r1_cn;
    logic [CW-1:0] r1_am, r1_bm, r1_cm;
    // stage 2
    logic               r2_v, r2_an, r2_bn, r2_cn, r2_za, r2_zb, r2_zc;
    logic [CW-1:0]      r2_am, r2_bm, r2_cm;
    logic [2*HW-1:0]    r2_bll, r2_all;
    logic [HW+HH-1:0]   r2_blh, r2_alh, r2_ahl;
    logic [2*HH-1:0]    r2_bhh, r2_ahh;
    logic [THR_W+HW-1:0] r2_rbl, r2_rcl;
    logic [THR_W+HH-1:0] r2_rbh, r2_rch;
    // stage 3
    logic          r3_v, r3_an, r3_bn, r3_cn, r3_za, r3_zb, r3_zc;
    logic [CW-1:0] r3_am, r3_bm, r3_cm;
    logic [PW-1:0] r3_b2, r3_ac;
    logic [RW-1:0] r3_rb, r3_rc;
    // stage 4
    logic          r4_v, r4_an, r4_bn, r4_cn, r4_zb, r4_zc, r4_linear, r4_dneg;
    logic [CW-1:0] r4_am, r4_bm, r4_cm;
    logic [DW-1:0] r4_dis;
    // stage 5
    logic          r5_v;
    t_flags        r5_flags;
    logic [CW-1:0] r5_am, r5_bm, r5_cm;
    logic [DW-1:0] r5_dis;

    logic [CW-1:0]   n1_am, n1_bm, n1_cm;
    logic            n4_nab, n4_nac;
    logic [DW-1:0]   n4_b2, n4_ac4, n4_dis;
    logic            n4_dneg;
    logic [CMPW-1:0] n5_eps;
    logic            n5_big;
    t_flags          n5_flags;

    assign n1_am = i_a[CW-1] ? CW'(-i_a) : CW'(i_a);
    assign n1_bm = i_b[CW-1] ? CW'(-i_b) : CW'(i_b);
    assign n1_cm = i_c[CW-1] ? CW'(-i_c) : CW'(i_c);

    always_comb begin
        n4_nab  = (r3_bm != '0) && ((RW'(r3_am) << THR_W) < r3_rb);
        n4_nac  = (r3_cm != '0) && ((RW'(r3_am) << THR_W) < r3_rc);
        n4_b2   = DW'(r3_b2);
        n4_ac4  = DW'(r3_ac) << 2;
        n4_dneg = 1'b0;
        if (r3_an != r3_cn) begin
            n4_dis = n4_b2 + n4_ac4;
        end else if (n4_b2 >= n4_ac4) begin
            n4_dis = n4_b2 - n4_ac4;
        end else begin
            n4_dis  = n4_ac4 - n4_b2;
            n4_dneg = 1'b1;
        end
    end

    always_comb begin
        n5_eps = CMPW'(i_zero_thr) << FRAC_BITS;
        n5_big = CMPW'(r4_dis) >= n5_eps;
        n5_flags.linear = r4_linear;
        n5_flags.neg_a  = r4_an;
        n5_flags.neg_b  = r4_bn;
        n5_flags.neg_c  = r4_cn;
        if (r4_linear) begin
            if (r4_zb && r4_zc) begin
                n5_flags.outcome = OUT_INF;
            end else if (r4_zb) begin
                n5_flags.outcome = OUT_NONE;
            end else begin
                n5_flags.outcome = OUT_ONE;
            end
        end else if (r4_dneg && n5_big) begin
            n5_flags.outcome = OUT_NONE;
        end else if (!n5_big) begin
            n5_flags.outcome = OUT_ONE;
        end else begin
            n5_flags.outcome = OUT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_an <= i_a[CW-1];
            r1_bn <= i_b[CW-1];
            r1_cn <= i_c[CW-1];
            r1_am <= n1_am;
            r1_bm <= n1_bm;
            r1_cm <= n1_cm;

            r2_an  <= r1_an;
            r2_bn  <= r1_bn;
            r2_cn  <= r1_cn;
            r2_am  <= r1_am;
            r2_bm  <= r1_bm;
            r2_cm  <= r1_cm;
            r2_za  <= MCW'(r1_am) < MCW'(i_zero_thr);
            r2_zb  <= MCW'(r1_bm) < MCW'(i_zero_thr);
            r2_zc  <= MCW'(r1_cm) < MCW'(i_zero_thr);
            r2_bll <= r1_bm[HW-1:0] * r1_bm[HW-1:0];
            r2_blh <= r1_bm[HW-1:0] * r1_bm[CW-1:HW];
            r2_bhh <= r1_bm[CW-1:HW] * r1_bm[CW-1:HW];
            r2_all <= r1_am[HW-1:0] * r1_cm[HW-1:0];
            r2_alh <= r1_am[HW-1:0] * r1_cm[CW-1:HW];
            r2_ahl <= r1_am[CW-1:HW] * r1_cm[HW-1:0];
            r2_ahh <= r1_am[CW-1:HW] * r1_cm[CW-1:HW];
            r2_rbl <= i_ratio_thr * r1_bm[HW-1:0];
            r2_rbh <= i_ratio_thr * r1_bm[CW-1:HW];
            r2_rcl <= i_ratio_thr * r1_cm[HW-1:0];
            r2_rch <= i_ratio_thr * r1_cm[CW-1:HW];

            r3_an <= r2_an;
            r3_bn <= r2_bn;
            r3_cn <= r2_cn;
            r3_am <= r2_am;
            r3_bm <= r2_bm;
            r3_cm <= r2_cm;
            r3_za <= r2_za;
            r3_zb <= r2_zb;
            r3_zc <= r2_zc;
            r3_b2 <= PW'(r2_bll) + (PW'(r2_blh) << (HW + 1)) + (PW'(r2_bhh) << (2 * HW));
            r3_ac <= PW'(r2_all) + (PW'(r2_alh) << HW) + (PW'(r2_ahl) << HW)
                   + (PW'(r2_ahh) << (2 * HW));
            r3_rb <= RW'(r2_rbl) + (RW'(r2_rbh) << HW);
            r3_rc <= RW'(r2_rcl) + (RW'(r2_rch) << HW);

            r4_an     <= r3_an;
            r4_bn     <= r3_bn;
            r4_cn     <= r3_cn;
            r4_am     <= r3_am;
            r4_bm     <= r3_bm;
            r4_cm     <= r3_cm;
            r4_zb     <= r3_zb;
            r4_zc     <= r3_zc;
            r4_linear <= (n4_nab && n4_nac) || (n4_nab && r3_zc && !r3_zb)
                       || (n4_nac && r3_zb && !r3_za) || r3_za;
            r4_dis    <= n4_dis;
            r4_dneg   <= n4_dneg;

            r5_flags <= n5_flags;
            r5_am    <= r4_am;
            r5_bm    <= r4_bm;
            r5_cm    <= r4_cm;
            r5_dis   <= r4_dis;
        end
    end

    assign o_valid = r5_v;
    assign o_flags = r5_flags;
    assign o_am    = r5_am;
    assign o_bm    = r5_bm;
    assign o_cm    = r5_cm;
    assign o_dis   = r5_dis;

endmodule
`default_nettype wire

FILE: hw/rtl/qes_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qes_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qes_sqrt import qes_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2*COEF_WIDTH:0] i_dis,
    input  wire t_flags                i_flags,
    input  wire logic [COEF_WIDTH-1:0] i_am,
    input  wire logic [COEF_WIDTH-1:0] i_bm,
    input  wire logic [COEF_WIDTH-1:0] i_cm,
    output logic                       o_valid,
    output logic [COEF_WIDTH:0]        o_root,
    output t_flags                     o_flags,
    output logic [COEF_WIDTH-1:0]      o_am,
    output logic [COEF_WIDTH-1:0]      o_bm,
    output logic [COEF_WIDTH-1:0]      o_cm
);

    localparam int CW  = COEF_WIDTH;
    localparam int SW  = CW + 1;
    localparam int WK  = 2 * SW;
    localparam int RMW = SW + 2;

    logic          r_v     [SW];
    logic [RMW-1:0] r_rem  [SW];
    logic [SW-1:0] r_root  [SW];
    logic [WK-1:0] r_work  [SW];
    t_flags        r_flags [SW];
    logic [CW-1:0] r_am    [SW];
    logic [CW-1:0] r_bm    [SW];
    logic [CW-1:0] r_cm    [SW];

    logic           s_v     [SW];
    logic [RMW-1:0] s_rem   [SW];
    logic [SW-1:0]  s_root  [SW];
    logic [WK-1:0]  s_work  [SW];
    t_flags         s_flags [SW];
    logic [CW-1:0]  s_am    [SW];
    logic [CW-1:0]  s_bm    [SW];
    logic [CW-1:0]  s_cm    [SW];

    logic [RMW+1:0] t_val   [SW];
    logic [RMW+1:0] t_trial [SW];
    logic           t_ge    [SW];
    logic [RMW-1:0] n_rem   [SW];
    logic [SW-1:0]  n_root  [SW];
    logic [WK-1:0]  n_work  [SW];

    always_comb begin
        s_v[0]     = i_valid;
        s_rem[0]   = '0;
        s_root[0]  = '0;
        s_work[0]  = WK'(i_dis);
        s_flags[0] = i_flags;
        s_am[0]    = i_am;
        s_bm[0]    = i_bm;
        s_cm[0]    = i_cm;
        for (int i = 1; i < SW; i++) begin
            s_v[i]     = r_v[i-1];
            s_rem[i]   = r_rem[i-1];
            s_root[i]  = r_root[i-1];
            s_work[i]  = r_work[i-1];
            s_flags[i] = r_flags[i-1];
            s_am[i]    = r_am[i-1];
            s_bm[i]    = r_bm[i-1];
            s_cm[i]    = r_cm[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < SW; i++) begin
            t_val[i]   = {s_rem[i], s_work[i][WK-1 -: 2]};
            t_trial[i] = {RMW'(s_root[i]), 2'b01};
            t_ge[i]    = t_val[i] >= t_trial[i];
            n_rem[i]   = t_ge[i] ? RMW'(t_val[i] - t_trial[i]) : RMW'(t_val[i]);
            n_root[i]  = {s_root[i][SW-2:0], t_ge[i]};
            n_work[i]  = s_work[i] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SW; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            for (int i = 0; i < SW; i++) begin
                r_v[i] <= s_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < SW; i++) begin
                r_rem[i]   <= n_rem[i];
                r_root[i]  <= n_root[i];
                r_work[i]  <= n_work[i];
                r_flags[i] <= s_flags[i];
                r_am[i]    <= s_am[i];
                r_bm[i]    <= s_bm[i];
                r_cm[i]    <= s_cm[i];
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_flags = r_flags[SW-1];
    assign o_am    = r_am[SW-1];
    assign o_bm    = r_bm[SW-1];
    assign o_cm    = r_cm[SW-1];

endmodule
`default_nettype wire

FILE: hw/rtl/qes_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qes_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qes_div import qes_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire t_flags                                 i_flags,
    input  wire t_lane [1:0]                            i_lane,
    input  wire logic [1:0][COEF_WIDTH+FRAC_BITS:0]     i_num,
    input  wire logic [1:0][COEF_WIDTH:0]               i_den,
    output logic                                        o_valid,
    output t_flags                                      o_flags,
    output t_lane [1:0]                                 o_lane,
    output logic [1:0][COEF_WIDTH+FRAC_BITS:0]          o_quot
);

    localparam int QW  = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int DNW = COEF_WIDTH + 1;

    logic                     r_v     [QW];
    t_flags                   r_flags [QW];
    t_lane [1:0]              r_lane  [QW];
    logic [1:0][DNW-1:0]      r_rem   [QW];
    logic [1:0][QW-1:0]       r_work  [QW];
    logic [1:0][DNW-1:0]      r_den   [QW];

    logic                     s_v     [QW];
    t_flags                   s_flags [QW];
    t_lane [1:0]              s_lane  [QW];
    logic [1:0][DNW-1:0]      s_rem   [QW];
    logic [1:0][QW-1:0]       s_work  [QW];
    logic [1:0][DNW-1:0]      s_den   [QW];

    logic [1:0][DNW:0]        t_val   [QW];
    logic [1:0]               t_ge    [QW];
    logic [1:0][DNW-1:0]      n_rem   [QW];
    logic [1:0][QW-1:0]       n_work  [QW];

    always_comb begin
        s_v[0]     = i_valid;
        s_flags[0] = i_flags;
        s_lane[0]  = i_lane;
        s_rem[0]   = '0;
        s_work[0]  = i_num;
        s_den[0]   = i_den;
        for (int i = 1; i < QW; i++) begin
            s_v[i]     = r_v[i-1];
            s_flags[i] = r_flags[i-1];
            s_lane[i]  = r_lane[i-1];
            s_rem[i]   = r_rem[i-1];
            s_work[i]  = r_work[i-1];
            s_den[i]   = r_den[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < QW; i++) begin
            for (int l = 0; l < 2; l++) begin
                t_val[i][l]  = {s_rem[i][l], s_work[i][l][QW-1]};
                t_ge[i][l]   = t_val[i][l] >= {1'b0, s_den[i][l]};
                n_rem[i][l]  = t_ge[i][l] ? DNW'(t_val[i][l] - {1'b0, s_den[i][l]})
                                          : DNW'(t_val[i][l]);
                n_work[i][l] = {s_work[i][l][QW-2:0], t_ge[i][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QW; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            for (int i = 0; i < QW; i++) begin
                r_v[i] <= s_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < QW; i++) begin
                r_flags[i] <= s_flags[i];
                r_lane[i]  <= s_lane[i];
                r_rem[i]   <= n_rem[i];
                r_work[i]  <= n_work[i];
                r_den[i]   <= s_den[i];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_flags = r_flags[QW-1];
    assign o_lane  = r_lane[QW-1];
    assign o_quot  = r_work[QW-1];

endmodule
`default_nettype wire

FILE: hw/rtl/qes_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qes_finish
// Saturation, zero forcing and sign of both roots; output register.
// ----------------------------------------------------------------------------
module qes_finish import qes_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire t_flags                             i_flags,
    input  wire t_lane [1:0]                        i_lane,
    input  wire logic [1:0][COEF_WIDTH+FRAC_BITS:0] i_quot,
    input  wire logic [THR_W-1:0]                   i_zero_thr,
    output logic                                    o_valid,
    output logic [1:0]                              o_outcome,
    output logic                                    o_was_linear,
    output logic signed [ROOT_W-1:0]                o_root_first,
    output logic signed [ROOT_W-1:0]                o_root_second,
    output logic                                    o_saturated
);

    localparam int QW = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int EW = (QW > ROOT_W) ? QW : ROOT_W;
    localparam logic [ROOT_W-1:0] TOP  = {1'b1, {(ROOT_W-1){1'b0}}};
    localparam logic [ROOT_W-1:0] MAXP = {1'b0, {(ROOT_W-1){1'b1}}};

    logic              r_valid;
    logic [1:0]        r_outcome;
    logic              r_linear;
    logic [ROOT_W-1:0] r_root [2];
    logic              r_sat;

    logic [EW-1:0]     n_limit [2];
    logic [EW-1:0]     n_clip  [2];
    logic [ROOT_W-1:0] n_mag   [2];
    logic [ROOT_W-1:0] n_root  [2];
    logic              n_sat   [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_limit[l] = i_lane[l].neg ? EW'(TOP) : EW'(MAXP);
            n_clip[l]  = EW'(i_quot[l]);
            n_mag[l]   = '0;
            n_root[l]  = '0;
            n_sat[l]   = 1'b0;
            if (i_lane[l].num_zero) begin
                n_root[l] = '0;
            end else if (i_lane[l].den_zero) begin
                n_sat[l]  = 1'b1;
                n_root[l] = i_lane[l].num_neg ? TOP : MAXP;
            end else begin
                if (n_clip[l] > n_limit[l]) begin
                    n_sat[l]  = 1'b1;
                    n_clip[l] = n_limit[l];
                end
                n_mag[l] = n_clip[l][ROOT_W-1:0];
                if (n_clip[l] < EW'(i_zero_thr)) begin
                    n_root[l] = '0;
                end else begin
                    n_root[l] = i_lane[l].neg ? (~n_mag[l] + 1'b1) : n_mag[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_outcome <= i_flags.outcome;
            r_linear  <= i_flags.linear;
            r_root[0] <= n_root[0];
            r_root[1] <= n_root[1];
            r_sat     <= n_sat[0] | n_sat[1];
        end
    end

    assign o_valid       = r_valid;
    assign o_outcome     = r_outcome;
    assign o_was_linear  = r_linear;
    assign o_root_first  = r_root[0];
    assign o_root_second = r_root[1];
    assign o_saturated   = r_sat;

endmodule
`default_nettype wire
